>>> hw/rtl/gbsl_pkg.sv
// Shared constants, types and state encodings of the Gabor bank spike latency core.
`default_nettype none

package gbsl_pkg;

  localparam int KERNEL_SIZE_DEF = 5;
  localparam int NUM_ORI_DEF     = 4;
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_HEIGHT      = 1024;
  localparam int QUEUE_DEPTH     = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE        = 2'd3;

  typedef struct packed {
    logic        is_coef;
    logic [6:0]  coef_index;
    logic [15:0] coef_value;
    logic        full;
    logic [9:0]  row;
    logic [9:0]  column;
  } cmd_t;

  typedef struct packed {
    logic [15:0] threshold;
    logic [3:0]  scale;
  } cfg_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_UPD,
    F_PUSH
  } fstate_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SUMSQ,
    B_SQRT,
    B_THR,
    B_CONV,
    B_CMP,
    B_DIVINIT,
    B_DIV,
    B_EMIT,
    B_FLUSH
  } bstate_t;

endpackage

`default_nettype wire

>>> hw/rtl/gbsl_front.sv
// Front end: configuration registers, raster counters, line store and window.
`default_nettype none

module gbsl_front #(
  parameter int KERNEL_SIZE = gbsl_pkg::KERNEL_SIZE_DEF,
  parameter int MAX_WIDTH   = gbsl_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_kind,
  input  logic [6:0]                        in_coef_index,
  input  logic signed [15:0]                in_coef_value,
  input  logic [7:0]                        in_pixel,
  input  logic                              cfg_we,
  input  logic [gbsl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gbsl_pkg::CFG_DATA_W-1:0]   cfg_data,
  output gbsl_pkg::cfg_t                    cfg_o,
  output logic                              q_push_valid,
  input  logic                              q_push_ready,
  output gbsl_pkg::cmd_t                    q_cmd,
  output logic [KERNEL_SIZE*KERNEL_SIZE*8-1:0] q_win
);

  localparam int KK    = KERNEL_SIZE * KERNEL_SIZE;
  localparam int LINES = KERNEL_SIZE - 1;
  localparam int HALF  = KERNEL_SIZE / 2;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int EWW   = $clog2(MAX_WIDTH + 1);
  localparam int LW    = 8 * LINES;

  gbsl_pkg::fstate_t state_r, state_nxt;
  gbsl_pkg::cmd_t    cmd_r;

  logic [10:0]   width_r, height_r;
  logic [15:0]   thr_r;
  logic [3:0]    scale_r;
  logic [9:0]    row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [7:0]    pix_r;
  logic [9:0]    rsel_r;
  logic [CW-1:0] csel_r;
  logic [7:0]    win_r [KK];
  logic [LW-1:0] lmem [MAX_WIDTH];
  logic [LW-1:0] rd_r;

  logic [EWW-1:0] eff_w;
  logic [10:0]    eff_h;
  logic [CW-1:0]  c_sel;
  logic [9:0]     r_sel;
  logic           accept;
  logic [31:0]    c_inc, r_inc;

  always_comb begin
    if (width_r == 11'd0) begin
      eff_w = EWW'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      eff_w = EWW'(MAX_WIDTH);
    end else begin
      eff_w = EWW'(width_r);
    end
    if (height_r == 11'd0) begin
      eff_h = 11'd1;
    end else if (32'(height_r) > gbsl_pkg::MAX_HEIGHT) begin
      eff_h = 11'(gbsl_pkg::MAX_HEIGHT);
    end else begin
      eff_h = height_r;
    end
    c_sel = (32'(col_r) >= 32'(eff_w)) ? CW'(eff_w - EWW'(1)) : col_r;
    r_sel = ({1'b0, row_r} >= eff_h) ? 10'(eff_h - 11'd1) : row_r;
  end

  assign accept = in_valid && !in_stall;
  assign c_inc  = 32'(csel_r) + 32'd1;
  assign r_inc  = 32'(rsel_r) + 32'd1;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (state_r == gbsl_pkg::F_UPD) begin
      if (c_inc >= 32'(eff_w)) begin
        col_nxt = '0;
        row_nxt = (r_inc >= 32'(eff_h)) ? 10'd0 : 10'(r_inc);
      end else begin
        col_nxt = CW'(c_inc);
        row_nxt = rsel_r;
      end
    end
    if (cfg_we && (cfg_index == gbsl_pkg::REG_IMAGE_WIDTH ||
                   cfg_index == gbsl_pkg::REG_IMAGE_HEIGHT)) begin
      row_nxt = '0;
      col_nxt = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gbsl_pkg::F_IDLE: begin
        if (accept) begin
          state_nxt = in_kind ? gbsl_pkg::F_UPD : gbsl_pkg::F_PUSH;
        end
      end
      gbsl_pkg::F_UPD:  state_nxt = gbsl_pkg::F_PUSH;
      gbsl_pkg::F_PUSH: begin
        if (q_push_ready) begin
          state_nxt = gbsl_pkg::F_IDLE;
        end
      end
      default: state_nxt = gbsl_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = (state_r != gbsl_pkg::F_IDLE);
    q_push_valid = (state_r == gbsl_pkg::F_PUSH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= gbsl_pkg::F_IDLE;
      width_r  <= 11'd1024;
      height_r <= 11'd1024;
      thr_r    <= 16'd655;
      scale_r  <= 4'd0;
      row_r    <= '0;
      col_r    <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          gbsl_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_data[10:0];
          gbsl_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_data[10:0];
          gbsl_pkg::REG_THRESHOLD:    thr_r    <= cfg_data;
          gbsl_pkg::REG_SCALE:        scale_r  <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == gbsl_pkg::F_IDLE && accept) begin
      cmd_r.is_coef    <= !in_kind;
      cmd_r.coef_index <= in_coef_index;
      cmd_r.coef_value <= in_coef_value;
      cmd_r.full       <= 1'b0;
      pix_r            <= in_pixel;
      rsel_r           <= r_sel;
      csel_r           <= c_sel;
    end
    if (state_r == gbsl_pkg::F_UPD) begin
      cmd_r.full   <= (32'(rsel_r) >= LINES) && (32'(csel_r) >= LINES);
      cmd_r.row    <= 10'(32'(rsel_r) - HALF);
      cmd_r.column <= 10'(32'(csel_r) - HALF);
      for (int k = 0; k < KERNEL_SIZE; k++) begin
        for (int i = 0; i < KERNEL_SIZE - 1; i++) begin
          win_r[k*KERNEL_SIZE+i] <= win_r[k*KERNEL_SIZE+i+1];
        end
        win_r[k*KERNEL_SIZE+KERNEL_SIZE-1] <= (k < LINES) ? rd_r[k*8 +: 8] : pix_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == gbsl_pkg::F_UPD) begin
      lmem[csel_r] <= {pix_r, rd_r[LW-1:8]};
    end
    rd_r <= lmem[c_sel];
  end

  for (genvar g = 0; g < KK; g++) begin : g_flat
    assign q_win[g*8 +: 8] = win_r[g];
  end

  assign q_cmd           = cmd_r;
  assign cfg_o.threshold = thr_r;
  assign cfg_o.scale     = scale_r;

endmodule

`default_nettype wire

>>> hw/rtl/gbsl_queue.sv
// Short first-in first-out queue between the front end and the back end.
`default_nettype none

module gbsl_queue #(
  parameter int W     = 8,
  parameter int DEPTH = gbsl_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [NW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign push_ready = (32'(cnt_r) < DEPTH);
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (32'(wp_r) == DEPTH - 1) ? '0 : PW'(32'(wp_r) + 32'd1);
      end
      if (do_pop) begin
        rp_r <= (32'(rp_r) == DEPTH - 1) ? '0 : PW'(32'(rp_r) + 32'd1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + NW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/gbsl_back.sv
// Back end: kernel store, norm, correlation, thresholding, latency division and output.
`default_nettype none

module gbsl_back #(
  parameter int KERNEL_SIZE = gbsl_pkg::KERNEL_SIZE_DEF,
  parameter int NUM_ORI     = gbsl_pkg::NUM_ORI_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_valid,
  output logic                                 q_pop,
  input  gbsl_pkg::cmd_t                       q_cmd,
  input  logic [KERNEL_SIZE*KERNEL_SIZE*8-1:0] q_win,
  input  gbsl_pkg::cfg_t                       cfg_i,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [15:0]                          out_latency,
  output logic [9:0]                           out_row,
  output logic [9:0]                           out_column,
  output logic [1:0]                           out_orientation,
  output logic [3:0]                           out_scale,
  output logic                                 out_last
);

  localparam int KK   = KERNEL_SIZE * KERNEL_SIZE;
  localparam int IW   = $clog2(KK);
  localparam int SW   = $clog2(KK * 65025 + 1);
  localparam int NW   = (SW + 17) / 2;
  localparam int AW   = 25 + $clog2(KK);
  localparam int KN   = NUM_ORI * KK;
  localparam int KAW  = $clog2(KN + 1);
  localparam int OW   = (NUM_ORI > 1) ? $clog2(NUM_ORI) : 1;
  localparam int CMW  = (AW + 10 > 16 + NW) ? AW + 10 : 16 + NW;
  localparam int MX1  = (KK > NW) ? KK : NW;
  localparam int MAXC = (MX1 > 16) ? MX1 : 16;
  localparam int CNTW = $clog2(MAXC + 1);

  gbsl_pkg::bstate_t state_r, state_nxt;

  logic [7:0]           win_r [KK];
  logic [9:0]           row_r, col_r;
  logic [CNTW-1:0]      cnt_r;
  logic [SW-1:0]        sumsq_r;
  logic [2*NW-1:0]      rad_r;
  logic [NW+1:0]        rem_r;
  logic [NW-1:0]        root_r, norm_r;
  logic [16+NW-1:0]     thrn_r;
  logic [15:0]          kmem [KN];
  logic [15:0]          krd_r;
  logic [KAW-1:0]       kaddr_r;
  logic                 mac_en_r;
  logic [IW-1:0]        widx_r;
  logic signed [AW-1:0] acc_r;
  logic [AW-1:0]        a_r, drem_r;
  logic [15:0]          dsh_r, q_r, lat_r;
  logic [OW-1:0]        ori_r;
  logic                 pend_valid_r;
  logic [15:0]          pend_lat_r;
  logic [OW-1:0]        pend_ori_r;
  logic                 out_valid_r;

  logic [15:0]          sq;
  logic [SW-1:0]        sumsq_nxt;
  logic [NW+1:0]        rem_sh, trial;
  logic                 ge;
  logic [NW-1:0]        root_step;
  logic signed [24:0]   prod;
  logic [AW-1:0]        a_abs;
  logic                 pass, sat, last_ori, out_free, kwe, load_out;
  logic [AW:0]          dsh;
  logic                 dge;
  logic [15:0]          q_nxt;

  assign sq        = win_r[cnt_r[IW-1:0]] * win_r[cnt_r[IW-1:0]];
  assign sumsq_nxt = sumsq_r + SW'(sq);
  assign rem_sh    = {rem_r[NW-1:0], rad_r[2*NW-1 -: 2]};
  assign trial     = {root_r, 2'b01};
  assign ge        = (rem_sh >= trial);
  assign root_step = {root_r[NW-2:0], ge};
  assign prod      = $signed(krd_r) * $signed({1'b0, win_r[widx_r]});
  assign a_abs     = acc_r[AW-1] ? (~acc_r + AW'(1)) : acc_r;
  assign pass      = (CMW'({a_abs, 10'd0}) >= CMW'(thrn_r));
  assign sat       = (CMW'(norm_r) >= CMW'({a_r, 2'b00}));
  assign dsh       = {drem_r, dsh_r[15]};
  assign dge       = (dsh >= {1'b0, a_r});
  assign q_nxt     = {q_r[14:0], dge};
  assign last_ori  = (32'(ori_r) == NUM_ORI - 1);
  assign out_free  = !out_valid_r || !out_stall;
  assign kwe       = (state_r == gbsl_pkg::B_IDLE) && q_valid && q_cmd.is_coef &&
                     (32'(q_cmd.coef_index) < KN);
  assign load_out  = pend_valid_r && out_free &&
                     (state_r == gbsl_pkg::B_EMIT || state_r == gbsl_pkg::B_FLUSH);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gbsl_pkg::B_IDLE: begin
        if (q_valid && !q_cmd.is_coef && q_cmd.full) begin
          state_nxt = gbsl_pkg::B_SUMSQ;
        end
      end
      gbsl_pkg::B_SUMSQ: begin
        if (cnt_r == CNTW'(KK - 1)) begin
          state_nxt = gbsl_pkg::B_SQRT;
        end
      end
      gbsl_pkg::B_SQRT: begin
        if (cnt_r == CNTW'(NW - 1)) begin
          state_nxt = gbsl_pkg::B_THR;
        end
      end
      gbsl_pkg::B_THR: state_nxt = gbsl_pkg::B_CONV;
      gbsl_pkg::B_CONV: begin
        if (cnt_r == CNTW'(KK) && !mac_en_r) begin
          state_nxt = gbsl_pkg::B_CMP;
        end
      end
      gbsl_pkg::B_CMP: begin
        if (pass) begin
          state_nxt = gbsl_pkg::B_DIVINIT;
        end else begin
          state_nxt = last_ori ? gbsl_pkg::B_FLUSH : gbsl_pkg::B_CONV;
        end
      end
      gbsl_pkg::B_DIVINIT: state_nxt = sat ? gbsl_pkg::B_EMIT : gbsl_pkg::B_DIV;
      gbsl_pkg::B_DIV: begin
        if (cnt_r == CNTW'(15)) begin
          state_nxt = gbsl_pkg::B_EMIT;
        end
      end
      gbsl_pkg::B_EMIT: begin
        if (!pend_valid_r || out_free) begin
          state_nxt = last_ori ? gbsl_pkg::B_FLUSH : gbsl_pkg::B_CONV;
        end
      end
      gbsl_pkg::B_FLUSH: begin
        if (!pend_valid_r || out_free) begin
          state_nxt = gbsl_pkg::B_IDLE;
        end
      end
      default: state_nxt = gbsl_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state_r == gbsl_pkg::B_IDLE);
    out_valid = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= gbsl_pkg::B_IDLE;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      mac_en_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == gbsl_pkg::B_EMIT && (!pend_valid_r || out_free)) begin
        pend_valid_r <= 1'b1;
      end else if (state_r == gbsl_pkg::B_FLUSH && out_free) begin
        pend_valid_r <= 1'b0;
      end
      if (state_r == gbsl_pkg::B_CONV) begin
        mac_en_r <= (cnt_r < CNTW'(KK));
      end else begin
        mac_en_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      gbsl_pkg::B_IDLE: begin
        if (q_valid && !q_cmd.is_coef && q_cmd.full) begin
          for (int i = 0; i < KK; i++) begin
            win_r[i] <= q_win[i*8 +: 8];
          end
          row_r   <= q_cmd.row;
          col_r   <= q_cmd.column;
          cnt_r   <= '0;
          sumsq_r <= '0;
        end
      end
      gbsl_pkg::B_SUMSQ: begin
        sumsq_r <= sumsq_nxt;
        cnt_r   <= cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(KK - 1)) begin
          cnt_r  <= '0;
          rad_r  <= (2*NW)'(sumsq_nxt) << 16;
          rem_r  <= '0;
          root_r <= '0;
        end
      end
      gbsl_pkg::B_SQRT: begin
        rad_r  <= rad_r << 2;
        rem_r  <= ge ? (rem_sh - trial) : rem_sh;
        root_r <= root_step;
        cnt_r  <= cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(NW - 1)) begin
          norm_r <= (sumsq_r == '0) ? NW'(256) : root_step;
        end
      end
      gbsl_pkg::B_THR: begin
        thrn_r  <= cfg_i.threshold * norm_r;
        ori_r   <= '0;
        kaddr_r <= '0;
        cnt_r   <= '0;
        acc_r   <= '0;
      end
      gbsl_pkg::B_CONV: begin
        if (cnt_r < CNTW'(KK)) begin
          kaddr_r <= kaddr_r + KAW'(1);
          widx_r  <= cnt_r[IW-1:0];
          cnt_r   <= cnt_r + CNTW'(1);
        end
        if (mac_en_r) begin
          acc_r <= acc_r + AW'(prod);
        end
      end
      gbsl_pkg::B_CMP: begin
        a_r <= a_abs;
        if (!pass && !last_ori) begin
          ori_r <= ori_r + OW'(1);
          cnt_r <= '0;
          acc_r <= '0;
        end
      end
      gbsl_pkg::B_DIVINIT: begin
        lat_r  <= 16'hFFFF;
        drem_r <= AW'(norm_r >> 2);
        dsh_r  <= {norm_r[1:0], 14'd0};
        cnt_r  <= '0;
        q_r    <= '0;
      end
      gbsl_pkg::B_DIV: begin
        drem_r <= dge ? AW'(dsh - {1'b0, a_r}) : AW'(dsh);
        dsh_r  <= dsh_r << 1;
        q_r    <= q_nxt;
        cnt_r  <= cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(15)) begin
          lat_r <= q_nxt;
        end
      end
      gbsl_pkg::B_EMIT: begin
        if (!pend_valid_r || out_free) begin
          pend_lat_r <= lat_r;
          pend_ori_r <= ori_r;
          if (!last_ori) begin
            ori_r <= ori_r + OW'(1);
            cnt_r <= '0;
            acc_r <= '0;
          end
        end
      end
      gbsl_pkg::B_FLUSH: ;
      default: ;
    endcase
    if (load_out) begin
      out_latency     <= pend_lat_r;
      out_row         <= row_r;
      out_column      <= col_r;
      out_orientation <= 2'(pend_ori_r);
      out_scale       <= cfg_i.scale;
      out_last        <= (state_r == gbsl_pkg::B_FLUSH);
    end
  end

  always_ff @(posedge clk) begin
    if (kwe) begin
      kmem[KAW'(q_cmd.coef_index)] <= q_cmd.coef_value;
    end
    krd_r <= kmem[kaddr_r];
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gbsl_pkg::B_DIV) |-> (a_r != '0))
    else $error("division entered with zero divisor");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gbsl_pkg::B_IDLE) |-> !pend_valid_r)
    else $error("spike left pending when the pixel finished");

  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == gbsl_pkg::B_EMIT ||
                            $past(state_r) == gbsl_pkg::B_FLUSH))
    else $error("output loaded outside the emit states");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/gabor_bank_spike_latency_core.sv
// Top level of the Gabor filter bank with latency-coded spike output.
// Input beats either load one kernel coefficient or deliver one raster pixel;
// the front end takes a new beat only once the last one has been pushed into
// the queue to the back end, so it stalls while that queue is full, and a
// pixel passes through a window update step first. The back end sets the
// throughput: a coefficient or a pixel whose window is not complete is taken
// in the idle state. A complete window runs the sum of squares over its K*K
// pixels, a bit-serial square root of one step per norm bit and the threshold
// product, then per orientation the multiply-accumulate over the kernel store
// and the compare. Each spike adds the latency division and the hand-off to
// the output, with no division when the latency saturates, and a closing
// flush state ends the pixel, plus any wait on out_stall. The line store is
// one memory of MAX_WIDTH words of 8*(K-1) bits and needs no clearing pass.
`default_nettype none

module gabor_bank_spike_latency_core #(
  parameter int KERNEL_SIZE = gbsl_pkg::KERNEL_SIZE_DEF,
  parameter int NUM_ORI     = gbsl_pkg::NUM_ORI_DEF,
  parameter int MAX_WIDTH   = gbsl_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_kind,
  input  logic [6:0]                      in_coef_index,
  input  logic signed [15:0]              in_coef_value,
  input  logic [7:0]                      in_pixel,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [15:0]                     out_latency,
  output logic [9:0]                      out_row,
  output logic [9:0]                      out_column,
  output logic [1:0]                      out_orientation,
  output logic [3:0]                      out_scale,
  output logic                            out_last,
  input  logic                            cfg_we,
  input  logic [gbsl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbsl_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int WB = KERNEL_SIZE * KERNEL_SIZE * 8;
  localparam int QW = $bits(gbsl_pkg::cmd_t) + WB;

  gbsl_pkg::cmd_t f_cmd, b_cmd;
  gbsl_pkg::cfg_t cfg;
  logic [WB-1:0]  f_win, b_win;
  logic           push_valid, push_ready, pop_valid, pop_ready;
  logic [QW-1:0]  pop_data;

  gbsl_front #(
    .KERNEL_SIZE (KERNEL_SIZE),
    .MAX_WIDTH   (MAX_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_coef_index (in_coef_index),
    .in_coef_value (in_coef_value),
    .in_pixel      (in_pixel),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cfg_o         (cfg),
    .q_push_valid  (push_valid),
    .q_push_ready  (push_ready),
    .q_cmd         (f_cmd),
    .q_win         (f_win)
  );

  gbsl_queue #(
    .W     (QW),
    .DEPTH (gbsl_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({f_cmd, f_win}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign b_cmd = pop_data[QW-1:WB];
  assign b_win = pop_data[WB-1:0];

  gbsl_back #(
    .KERNEL_SIZE (KERNEL_SIZE),
    .NUM_ORI     (NUM_ORI)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (pop_valid),
    .q_pop           (pop_ready),
    .q_cmd           (b_cmd),
    .q_win           (b_win),
    .cfg_i           (cfg),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_latency     (out_latency),
    .out_row         (out_row),
    .out_column      (out_column),
    .out_orientation (out_orientation),
    .out_scale       (out_scale),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

>>> tb/gabor_bank_spike_latency_core_test.sv
// Self-checking testbench for the Gabor bank spike latency core.
`timescale 1ns / 100ps

module gabor_bank_spike_latency_core_test;

  localparam int K = 5;
  localparam int NORI = 4;
  localparam int KK = K * K;
  localparam int MAXW = 1024;
  localparam int SETTLE = 2000;

  typedef struct {
    bit        kind;
    bit [6:0]  coef_index;
    bit [15:0] coef_value;
    bit [7:0]  pixel;
  } beat_t;

  typedef struct {
    bit [15:0] latency;
    bit [9:0]  row;
    bit [9:0]  column;
    bit [1:0]  orientation;
    bit [3:0]  scale;
    bit        last;
  } spike_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_kind = 1'b0;
  logic [6:0] in_coef_index = '0;
  logic signed [15:0] in_coef_value = '0;
  logic [7:0] in_pixel = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] out_latency;
  logic [9:0] out_row;
  logic [9:0] out_column;
  logic [1:0] out_orientation;
  logic [3:0] out_scale;
  logic out_last;
  logic cfg_we = 1'b0;
  logic [gbsl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [gbsl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  beat_t pending[$];
  spike_t spikes_due[$];
  beat_t on_wire;
  bit steady = 1'b0;
  int errors = 0;

  bit [10:0] img_w = 11'd1024;
  bit [10:0] img_h = 11'd1024;
  bit [15:0] thresh = 16'd655;
  bit [3:0] scale_reg = 4'd0;
  int unsigned row_pos = 0;
  int unsigned col_pos = 0;
  bit [7:0] lines[K-1][MAXW];
  bit [7:0] win[K][K];
  bit signed [15:0] kern[NORI*KK];

  gabor_bank_spike_latency_core i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic void predict_spikes(beat_t bt);
    int unsigned w, h, r, c;
    longint unsigned sumsq, norm, mag, lat;
    longint signed acc;
    int n;
    spike_t s;
    if (!bt.kind) begin
      if (bt.coef_index < NORI * KK) kern[bt.coef_index] = bt.coef_value;
      return;
    end
    w = (img_w == 0) ? 1 : (img_w > MAXW) ? MAXW : img_w;
    h = (img_h == 0) ? 1 : (img_h > 1024) ? 1024 : img_h;
    r = (row_pos >= h) ? h - 1 : row_pos;
    c = (col_pos >= w) ? w - 1 : col_pos;
    for (int k = 0; k < K; k++) begin
      for (int i = 0; i < K - 1; i++) win[k][i] = win[k][i+1];
      win[k][K-1] = (k < K - 1) ? lines[k][c] : bt.pixel;
    end
    for (int k = 0; k < K - 2; k++) lines[k][c] = lines[k+1][c];
    lines[K-2][c] = bt.pixel;
    if (r >= K - 1 && c >= K - 1) begin
      sumsq = 0;
      n = 0;
      foreach (win[a, b]) sumsq += win[a][b] * win[a][b];
      norm = (sumsq == 0) ? 256 : int_sqrt(sumsq << 16);
      for (int o = 0; o < NORI; o++) begin
        acc = 0;
        foreach (win[a, b]) acc += longint'(kern[o*KK + a*K + b]) * longint'(win[a][b]);
        mag = (acc < 0) ? -acc : acc;
        if (mag * 1024 >= longint'(thresh) * norm) begin
          lat = (mag == 0) ? 65535 : (norm << 14) / mag;
          if (lat > 65535) lat = 65535;
          s.latency = lat[15:0];
          s.row = 10'(r - 2);
          s.column = 10'(c - 2);
          s.orientation = o[1:0];
          s.scale = scale_reg;
          s.last = 1'b0;
          spikes_due.insert(spikes_due.size(), s);
          n++;
        end
      end
      if (n > 0) spikes_due[$].last = 1'b1;
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    row_pos = r;
    col_pos = c;
  endfunction

  always @(posedge clk) begin
    beat_t nxt;
    if (rst_n) begin
      if (in_valid && !in_stall) predict_spikes(on_wire);
      if (!in_valid || !in_stall) begin
        if (pending.size() > 0 && (steady || $urandom_range(99) >= 14)) begin
          nxt = pending.pop_front();
          on_wire <= nxt;
          in_valid <= 1'b1;
          in_kind <= nxt.kind;
          in_coef_index <= nxt.coef_index;
          in_coef_value <= nxt.coef_value;
          in_pixel <= nxt.pixel;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    spike_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (spikes_due.size() == 0) begin
          $error("spike with nothing expected: row %0d column %0d", out_row, out_column);
          errors++;
        end else begin
          e = spikes_due.pop_front();
          if (out_latency !== e.latency) begin
            $error("latency: expected %0d, got %0d", e.latency, out_latency);
            errors++;
          end
          if (out_row !== e.row) begin
            $error("row: expected %0d, got %0d", e.row, out_row);
            errors++;
          end
          if (out_column !== e.column) begin
            $error("column: expected %0d, got %0d", e.column, out_column);
            errors++;
          end
          if (out_orientation !== e.orientation) begin
            $error("orientation: expected %0d, got %0d", e.orientation, out_orientation);
            errors++;
          end
          if (out_scale !== e.scale) begin
            $error("scale: expected %0d, got %0d", e.scale, out_scale);
            errors++;
          end
          if (out_last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, out_last);
            errors++;
          end
        end
      end
      out_stall <= !steady && ($urandom_range(99) < 14);
    end
  end

  task automatic write_reg(input logic [gbsl_pkg::CFG_IDX_W-1:0] idx, input bit [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      gbsl_pkg::REG_IMAGE_WIDTH: begin
        img_w = val[10:0];
        row_pos = 0;
        col_pos = 0;
      end
      gbsl_pkg::REG_IMAGE_HEIGHT: begin
        img_h = val[10:0];
        row_pos = 0;
        col_pos = 0;
      end
      gbsl_pkg::REG_THRESHOLD: thresh = val;
      default: scale_reg = val[3:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending.size() > 0 || in_valid || spikes_due.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic push_coef(input int idx, input bit [15:0] val);
    beat_t bt;
    bt.kind = 1'b0;
    bt.coef_index = idx[6:0];
    bt.coef_value = val;
    bt.pixel = 8'($urandom);
    pending.insert(pending.size(), bt);
  endtask

  task automatic push_pixel(input bit [7:0] px);
    beat_t bt;
    bt.kind = 1'b1;
    bt.coef_index = 7'($urandom);
    bt.coef_value = 16'($urandom);
    bt.pixel = px;
    pending.insert(pending.size(), bt);
  endtask

  task automatic push_image(input int count, input int mode);
    for (int i = 0; i < count; i++) begin
      case (mode)
        0: push_pixel(8'd0);
        1: push_pixel(8'd255);
        default: begin
          if ($urandom_range(19) == 0) push_coef($urandom_range(127), 16'($urandom));
          push_pixel(($urandom_range(9) == 0) ? 8'($urandom_range(1) * 255) : 8'($urandom));
        end
      endcase
    end
  endtask

  initial begin
    int fed;
    int w, h;
    foreach (lines[a, b]) lines[a][b] = 8'd0;
    foreach (win[a, b]) win[a][b] = 8'd0;
    foreach (kern[i]) kern[i] = 16'sd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Kernels at the coefficient extremes and at zero, plus an index past the store.
    for (int i = 0; i < NORI * KK; i++) begin
      case (i / KK)
        0: push_coef(i, 16'h7fff);
        1: push_coef(i, 16'h8000);
        2: push_coef(i, 16'h0000);
        default: push_coef(i, (i % 2) ? 16'h8000 : 16'h7fff);
      endcase
    end
    push_coef(127, 16'h1234);
    drain();
    write_reg(gbsl_pkg::REG_IMAGE_WIDTH, 16'd5);
    write_reg(gbsl_pkg::REG_IMAGE_HEIGHT, 16'd5);
    write_reg(gbsl_pkg::REG_THRESHOLD, 16'd0);
    write_reg(gbsl_pkg::REG_SCALE, 16'd15);
    push_image(25, 0);
    push_image(25, 1);
    drain();
    write_reg(gbsl_pkg::REG_THRESHOLD, 16'hffff);
    push_image(25, 1);
    push_image(25, 2);
    drain();
    write_reg(gbsl_pkg::REG_IMAGE_WIDTH, 16'h07ff);
    write_reg(gbsl_pkg::REG_IMAGE_HEIGHT, 16'd0);
    push_image(12, 2);
    drain();
    write_reg(gbsl_pkg::REG_IMAGE_WIDTH, 16'd0);
    write_reg(gbsl_pkg::REG_IMAGE_HEIGHT, 16'h07ff);
    push_image(8, 2);
    drain();

    for (int i = 0; i < 40; i++) push_coef($urandom_range(NORI * KK - 1), 16'($urandom));
    drain();
    fed = 0;
    while (fed < 40) begin
      w = $urandom_range(10, 5);
      h = $urandom_range(8, 5);
      steady = (fed == 0);
      write_reg(gbsl_pkg::REG_IMAGE_WIDTH, 16'(w));
      write_reg(gbsl_pkg::REG_IMAGE_HEIGHT, 16'(h));
      write_reg(gbsl_pkg::REG_THRESHOLD,
                ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom_range(40000)));
      write_reg(gbsl_pkg::REG_SCALE, 16'($urandom_range(15)));
      push_image(w * h * $urandom_range(2, 1), 2);
      fed += pending.size();
      drain();
    end
    steady = 1'b0;

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
